FILE: sv/sorted_list_table_engine_assert.svh
// assertion macros for the sorted list table engine
// used by the rtl files that assert; needs clk and rst_n in scope
`ifndef SORTED_LIST_TABLE_ENGINE_ASSERT_SVH
`define SORTED_LIST_TABLE_ENGINE_ASSERT_SVH

// same-cycle implication
`define SLTAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLTAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sltab_pkg.sv
// shared types and codes for the sorted list table engine
// no dependencies
package sltab_pkg;

  // request operation codes
  localparam logic [2:0] MODE_INS_SORTED = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [2:0] MODE_DELETE     = 3'd3;
  localparam logic [2:0] MODE_FIND       = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  // field widths
  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 6;
  localparam int unsigned CNT_W = 7;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_UP_RD,
    ST_UP_WR,
    ST_PUT,
    ST_DN_RD,
    ST_DN_WR,
    ST_DONE
  } state_t;

  // compare unit flags
  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_res_t;

endpackage

FILE: sv/sltab_store.sv
// single-port entry memory with registered read data
// depends on sltab_pkg
module sltab_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               addr,
  input  logic [sltab_pkg::VAL_W-1:0] wdata,
  output logic [sltab_pkg::VAL_W-1:0] rdata
);
  import sltab_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  // one address per cycle: written when we is high, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/sltab_cmp.sv
// shared compare unit: equality and signed greater-or-equal
// depends on sltab_pkg
module sltab_cmp (
  input  logic [sltab_pkg::VAL_W-1:0] entry,
  input  logic [sltab_pkg::VAL_W-1:0] key,
  output sltab_pkg::cmp_res_t         res
);
  import sltab_pkg::*;

  // signed order of the stored entry against the request value
  always_comb begin
    res.eq = (entry == key);
    res.ge = ($signed(entry) >= $signed(key));
  end

endmodule

FILE: sv/sorted_list_table_engine.sv
// Sorted list table engine: bounded list of signed 32-bit entries.
// One request goes in on the in_ channel (mode, item_value), one result comes
// out on the out_ channel (status, position, entry_count) per request.
// Modes: insert sorted, push front, push back, delete first match, find.
// Requests are handled one at a time; in_tready is high only while idle.
// Every entry touch goes through the single-port store, one read and one
// write per moved entry, one read and one compare per scanned entry.
// After the scan and any moves come the scan end, the slot write and the
// hand-off. A bare result (full list or unused mode) goes from idle
// straight to the done state. The next request is taken in the cycle after
// the hand-off, so no new request is taken before the last one is done.
// A finished result sits in an output register; if out_tready is low the
// sequencer holds in its done state and no new request is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; the store contents are left as they are and never read before
// being written. position wraps to its field width when CAPACITY exceeds 64,
// entry_count when CAPACITY exceeds 127.
// Depends on sltab_pkg, sltab_store, sltab_cmp and the assertion header.
`include "sorted_list_table_engine_assert.svh"

module sorted_list_table_engine #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode [2:0], item_value [34:3], zero [39:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status [1:0], position [7:2],
                                  // entry_count [14:8], zero [15]
);
  import sltab_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_t            state_r, state_nxt;
  logic [2:0]        mode_r, mode_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [VAL_W-1:0]  mem_wdata;
  logic [VAL_W-1:0]  mem_rdata;
  cmp_res_t          cmp_res;

  logic [2:0]        req_mode;
  logic [VAL_W-1:0]  req_value;
  logic              in_acc;
  logic              full;
  logic              hit;
  logic [CW-1:0]     idx_inc;
  logic [CW-1:0]     idx_dec;

  assign req_mode  = in_tdata[2:0];
  assign req_value = in_tdata[34:3];
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (cnt_r == CW'(CAPACITY));
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign hit       = (mode_r == MODE_INS_SORTED) ? cmp_res.ge : cmp_res.eq;

  sltab_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  sltab_cmp u_cmp (
    .entry (mem_rdata),
    .key   (val_r),
    .res   (cmp_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  // sequencer: next state, store access and result
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_cnt_nxt    = out_cnt_r;
    mem_we         = 1'b0;
    mem_addr       = idx_r[AW-1:0];
    mem_wdata      = mem_rdata;
    in_tready      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          mode_nxt   = req_mode;
          val_nxt    = req_value;
          idx_nxt    = '0;
          pos_nxt    = '0;
          status_nxt = STAT_OK;
          case (req_mode) inside
            MODE_INS_SORTED, MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
              if (full) begin
                status_nxt = STAT_FULL;
                state_nxt  = ST_DONE;
              end else if (req_mode == MODE_INS_SORTED) begin
                state_nxt = ST_SCAN_RD;
              end else begin
                idx_nxt   = cnt_r;
                pos_nxt   = (req_mode == MODE_PUSH_BACK) ? cnt_r : '0;
                state_nxt = ST_UP_RD;
              end
            end
            MODE_DELETE, MODE_FIND: begin
              state_nxt = ST_SCAN_RD;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // read the next entry, or end the scan past the last one
      ST_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          if (mode_r == MODE_INS_SORTED) begin
            pos_nxt   = cnt_r;
            idx_nxt   = cnt_r;
            state_nxt = ST_UP_RD;
          end else begin
            status_nxt = STAT_NOT_FOUND;
            pos_nxt    = '0;
            state_nxt  = ST_DONE;
          end
        end else begin
          state_nxt = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        if (hit) begin
          pos_nxt = idx_r;
          if (mode_r == MODE_INS_SORTED) begin
            idx_nxt   = cnt_r;
            state_nxt = ST_UP_RD;
          end else if (mode_r == MODE_DELETE) begin
            state_nxt = ST_DN_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SCAN_RD;
        end
      end

      // open a slot: move entries up one place from the tail down
      ST_UP_RD: begin
        if (idx_r == pos_r) begin
          state_nxt = ST_PUT;
        end else begin
          mem_addr  = idx_dec[AW-1:0];
          state_nxt = ST_UP_WR;
        end
      end

      ST_UP_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_dec;
        state_nxt = ST_UP_RD;
      end

      ST_PUT: begin
        mem_we    = 1'b1;
        mem_addr  = pos_r[AW-1:0];
        mem_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = ST_DONE;
      end

      // close a slot: move entries down one place from the hit upward
      ST_DN_RD: begin
        if (idx_inc >= cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ST_DONE;
        end else begin
          mem_addr  = idx_inc[AW-1:0];
          state_nxt = ST_DN_WR;
        end
      end

      ST_DN_WR: begin
        mem_we    = 1'b1;
        idx_nxt   = idx_inc;
        state_nxt = ST_DN_RD;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_status_nxt = status_r;
          out_pos_nxt    = POS_W'(pos_r);
          out_cnt_nxt    = CNT_W'(cnt_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_cnt_r, out_pos_r, out_status_r};

  // checks
  `SLTAB_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CW'(CAPACITY),
                    "entry count above capacity")
  `SLTAB_ASSERT_IMP(a_full_cnt, out_tvalid_r && out_status_r == STAT_FULL,
                    out_cnt_r == CNT_W'(CAPACITY), "full refusal with list not full")
  `SLTAB_ASSERT_IMP(a_miss_pos, out_tvalid_r && out_status_r == STAT_NOT_FOUND,
                    out_pos_r == '0, "missed lookup reports a position")
  `SLTAB_ASSERT_NXT(a_find_keeps, state_r != ST_IDLE && mode_r == MODE_FIND,
                    $stable(cnt_r), "find changed the entry count")

endmodule
